// ===== sv/qlt_pkg.sv =====
`default_nettype none

package qlt_pkg;

   localparam int BeatWidth   = 7;
   localparam int BarWidth    = 7;
   localparam int PhraseWidth = 16;
   localparam int TicksWidth  = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 16;
   localparam int LevelCount  = 9;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_BEATS_PER_BAR   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BARS_PER_PHRASE = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PULSE_TICKS     = 2'd2;

   localparam logic [BeatWidth-1:0]   BEATS_PER_BAR_RST   = 7'd4;
   localparam logic [BarWidth-1:0]    BARS_PER_PHRASE_RST = 7'd8;
   localparam logic [TicksWidth-1:0]  PULSE_TICKS_RST     = 16'd48;

   typedef struct packed {
      logic clock_level;
      logic arm_button_a;
      logic arm_jack_a;
      logic bar_select_a;
      logic phrase_select_a;
      logic arm_button_b;
      logic arm_jack_b;
      logic bar_select_b;
      logic phrase_select_b;
   } req_payload_type;

   typedef struct packed {
      logic                   trigger_a;
      logic                   trigger_b;
      logic                   armed_a;
      logic                   armed_b;
      logic                   phrase_mode_a;
      logic                   phrase_mode_b;
      logic [BeatWidth-1:0]   beat_shown;
      logic [BarWidth-1:0]    bar_shown;
      logic [PhraseWidth-1:0] phrase_shown;
   } rsp_payload_type;

   // rising edges seen by one channel on one tick
   typedef struct packed {
      logic arm_button;
      logic arm_jack;
      logic bar_select;
      logic phrase_select;
   } ch_edge_type;

   // position of the current clock event within bar and phrase
   typedef struct packed {
      logic beat_one;
      logic bar_one;
   } beat_pos_type;

   typedef struct packed {
      logic trigger;
      logic armed;
      logic phrase_mode;
   } ch_status_type;

endpackage

`default_nettype wire

// ===== sv/qlt_channel.sv =====
`default_nettype none

module qlt_channel (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire qlt_pkg::ch_edge_type            edges,
   input  wire qlt_pkg::beat_pos_type           pos,
   input  wire logic [qlt_pkg::TicksWidth-1:0]  pulse_ticks,
   output qlt_pkg::ch_status_type               status
);

   logic                           armed_ff, armed_in, armed_mid;
   logic                           mode_ff, mode_in;
   logic [qlt_pkg::TicksWidth-1:0] remaining_ff, remaining_in, remaining_mid;
   logic                           fire;

   always_comb begin
      // phrase select wins over bar select
      mode_in = mode_ff;
      if (edges.bar_select) begin
         mode_in = 1'b0;
      end
      if (edges.phrase_select) begin
         mode_in = 1'b1;
      end
      armed_mid = armed_ff | edges.arm_button | edges.arm_jack;
      fire      = armed_mid & pos.beat_one & (~mode_in | pos.bar_one);
      armed_in  = armed_mid & ~fire;

      remaining_mid = remaining_ff;
      if (fire && (pulse_ticks > remaining_ff)) begin
         remaining_mid = pulse_ticks;
      end
      status.trigger     = (remaining_mid != '0);
      status.armed       = armed_in;
      status.phrase_mode = mode_in;
      remaining_in = status.trigger ? remaining_mid - 1'b1 : remaining_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         mode_ff      <= 1'b0;
         remaining_ff <= '0;
      end else if (step) begin
         armed_ff     <= armed_in;
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/quantized_launch_trigger_unit.sv =====
`default_nettype none
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; a result waiting under stall
//   still lets one more item sit in the input register.
// Reset (synchronous, active high) empties both registers, restores the
//   configuration defaults and clears channel, counter and edge state.

module quantized_launch_trigger_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire qlt_pkg::req_payload_type          req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output qlt_pkg::rsp_payload_type               rsp_payload,
   input  wire logic                              csr_write_enable,
   input  wire logic [qlt_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [qlt_pkg::CsrDataWidth-1:0]  csr_data
);

   // configuration
   logic [qlt_pkg::BeatWidth-1:0]   beats_per_bar_ff;
   logic [qlt_pkg::BarWidth-1:0]    bars_per_phrase_ff;
   logic [qlt_pkg::TicksWidth-1:0]  pulse_ticks_ff;

   // input register
   logic                     in_valid_ff;
   qlt_pkg::req_payload_type in_item_ff;
   logic                     advance;

   // result register
   logic                     rsp_valid_ff;
   qlt_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // tick state
   logic [qlt_pkg::LevelCount-1:0]  prev_levels_ff, levels, edges;
   logic [qlt_pkg::BeatWidth-1:0]   beat_ff, beat_in, beat_disp_ff, beat_disp_in;
   logic [qlt_pkg::BarWidth-1:0]    bar_ff, bar_in, bar_disp_ff, bar_disp_in;
   logic [qlt_pkg::PhraseWidth-1:0] phrase_ff, phrase_in, phrase_disp_ff, phrase_disp_in;
   logic [qlt_pkg::BeatWidth:0]     beat_next;
   logic [qlt_pkg::BarWidth:0]      bar_next;
   logic                            beat;

   qlt_pkg::ch_edge_type   edges_a, edges_b;
   qlt_pkg::beat_pos_type  pos;
   qlt_pkg::ch_status_type status_a, status_b;

   // ---------------------------------------------------------------------
   // Handshake: the item in the input register moves on whenever the
   // result register is empty or its transfer completes this cycle.
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration writes; indexes beyond the list are dropped.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         beats_per_bar_ff   <= qlt_pkg::BEATS_PER_BAR_RST;
         bars_per_phrase_ff <= qlt_pkg::BARS_PER_PHRASE_RST;
         pulse_ticks_ff     <= qlt_pkg::PULSE_TICKS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            qlt_pkg::CSR_BEATS_PER_BAR: begin
               beats_per_bar_ff <= csr_data[qlt_pkg::BeatWidth-1:0];
            end
            qlt_pkg::CSR_BARS_PER_PHRASE: begin
               bars_per_phrase_ff <= csr_data[qlt_pkg::BarWidth-1:0];
            end
            qlt_pkg::CSR_PULSE_TICKS: begin
               pulse_ticks_ff <= csr_data[qlt_pkg::TicksWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Edge detection: a 0 to 1 change since the previous tick is an event.
   // The packed struct puts clock_level in the top bit.
   // ---------------------------------------------------------------------
   assign levels = in_item_ff;
   assign edges  = levels & ~prev_levels_ff;
   assign beat   = edges[qlt_pkg::LevelCount-1];

   always_comb begin
      edges_a.arm_button    = edges[7];
      edges_a.arm_jack      = edges[6];
      edges_a.bar_select    = edges[5];
      edges_a.phrase_select = edges[4];
      edges_b.arm_button    = edges[3];
      edges_b.arm_jack      = edges[2];
      edges_b.bar_select    = edges[1];
      edges_b.phrase_select = edges[0];
   end

   // firing looks at the counters before this tick's counting
   assign pos.beat_one = beat & (beat_ff == qlt_pkg::BeatWidth'(1));
   assign pos.bar_one  = (bar_ff == qlt_pkg::BarWidth'(1));

   qlt_channel u_channel_a (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .edges       (edges_a),
      .pos         (pos),
      .pulse_ticks (pulse_ticks_ff),
      .status      (status_a)
   );

   qlt_channel u_channel_b (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .edges       (edges_b),
      .pos         (pos),
      .pulse_ticks (pulse_ticks_ff),
      .status      (status_b)
   );

   // ---------------------------------------------------------------------
   // Beat, bar and phrase counting. Count one bit wider so a counter at the
   // top of its width returns to one instead of wrapping. The bar check
   // runs on every clock event, so a lowered limit takes effect at once.
   // ---------------------------------------------------------------------
   always_comb begin
      beat_in        = beat_ff;
      bar_in         = bar_ff;
      phrase_in      = phrase_ff;
      beat_disp_in   = beat_disp_ff;
      bar_disp_in    = bar_disp_ff;
      phrase_disp_in = phrase_disp_ff;
      beat_next      = {1'b0, beat_ff} + 1'b1;
      bar_next       = {1'b0, bar_ff};
      if (beat) begin
         beat_disp_in   = beat_ff;
         bar_disp_in    = bar_ff;
         phrase_disp_in = phrase_ff;
         if (beat_next > {1'b0, beats_per_bar_ff}) begin
            beat_in  = qlt_pkg::BeatWidth'(1);
            bar_next = {1'b0, bar_ff} + 1'b1;
         end else begin
            beat_in = beat_next[qlt_pkg::BeatWidth-1:0];
         end
         if (bar_next > {1'b0, bars_per_phrase_ff}) begin
            bar_in    = qlt_pkg::BarWidth'(1);
            phrase_in = phrase_ff + 1'b1;
         end else begin
            bar_in = bar_next[qlt_pkg::BarWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         beat_ff        <= qlt_pkg::BeatWidth'(1);
         bar_ff         <= qlt_pkg::BarWidth'(1);
         phrase_ff      <= qlt_pkg::PhraseWidth'(1);
         beat_disp_ff   <= '0;
         bar_disp_ff    <= qlt_pkg::BarWidth'(1);
         phrase_disp_ff <= qlt_pkg::PhraseWidth'(1);
      end else if (advance) begin
         prev_levels_ff <= levels;
         beat_ff        <= beat_in;
         bar_ff         <= bar_in;
         phrase_ff      <= phrase_in;
         beat_disp_ff   <= beat_disp_in;
         bar_disp_ff    <= bar_disp_in;
         phrase_disp_ff <= phrase_disp_in;
      end
   end

   // assemble the result of this tick
   always_comb begin
      rsp_payload_in.trigger_a     = status_a.trigger;
      rsp_payload_in.trigger_b     = status_b.trigger;
      rsp_payload_in.armed_a       = status_a.armed;
      rsp_payload_in.armed_b       = status_b.armed;
      rsp_payload_in.phrase_mode_a = status_a.phrase_mode;
      rsp_payload_in.phrase_mode_b = status_b.phrase_mode;
      rsp_payload_in.beat_shown    = beat_disp_in;
      rsp_payload_in.bar_shown     = bar_disp_in;
      rsp_payload_in.phrase_shown  = phrase_disp_in;
   end

endmodule

`default_nettype wire

// ===== sv/qlt_checker.sv =====
`default_nettype none

module qlt_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire qlt_pkg::rsp_payload_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // a new result follows an input transfer, through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transfer");

   // reset leaves both sides open and empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // the bar shown is counted from one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.bar_shown != '0)
      else $error("bar number zero shown");

endmodule

bind quantized_launch_trigger_unit qlt_checker u_qlt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
